@@ rtl/core/vlid_pkg.sv @@
// ----------------------------------------------------------------------------
// vlid_pkg
// Shared types and constants for the variable-length instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vlid_pkg;

    localparam int unsigned POS_W  = 7;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IMM_W  = 32;

    localparam logic [1:0] CLS_SHORT = 2'd0;
    localparam logic [1:0] CLS_IMM16 = 2'd1;
    localparam logic [1:0] CLS_FULL  = 2'd2;
    localparam logic [1:0] CLS_BLOCK = 2'd3;

    localparam logic [POS_W-1:0] LEN_SHORT      = 7'd2;
    localparam logic [POS_W-1:0] LEN_IMM16      = 7'd4;
    localparam logic [POS_W-1:0] LEN_FULL       = 7'd9;
    localparam logic [POS_W-1:0] LEN_BLOCK_BASE = 7'd2;

    localparam logic [POS_W-1:0] POS_TAG    = 7'd0;
    localparam logic [POS_W-1:0] POS_OP     = 7'd1;
    localparam logic [POS_W-1:0] POS_DEST   = 7'd2;
    localparam logic [POS_W-1:0] POS_SRC1   = 7'd3;
    localparam logic [POS_W-1:0] POS_SRC2   = 7'd4;
    localparam logic [POS_W-1:0] POS_IMM_B0 = 7'd5;
    localparam logic [POS_W-1:0] POS_IMM_B1 = 7'd6;
    localparam logic [POS_W-1:0] POS_IMM_B2 = 7'd7;
    localparam logic [POS_W-1:0] POS_IMM_B3 = 7'd8;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  exp_len;
        logic [1:0]        cls;
        logic [BYTE_W-1:0] opcode;
        logic [BYTE_W-1:0] dest;
        logic [BYTE_W-1:0] src1;
        logic [BYTE_W-1:0] src2;
        logic [IMM_W-1:0]  imm;
    } t_dec_state;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] opcode;
        logic [BYTE_W-1:0] dest;
        logic [BYTE_W-1:0] src1;
        logic [BYTE_W-1:0] src2;
        logic [IMM_W-1:0]  imm;
        logic [POS_W-1:0]  len;
    } t_dec_result;

    localparam t_dec_state  DEC_STATE_CLEAR = '0;
    localparam t_dec_result DEC_RESULT_ZERO = '0;

endpackage

`default_nettype wire

@@ rtl/core/vlid_step.sv @@
// ----------------------------------------------------------------------------
// vlid_step
// Next-state and result logic for one code byte: tag decode, field capture,
// completion and truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module vlid_step (
    input  vlid_pkg::t_dec_state  i_state,
    input  logic [7:0]            i_code_byte,
    input  logic                  i_last,
    output vlid_pkg::t_dec_state  o_state,
    output logic                  o_emit,
    output vlid_pkg::t_dec_result o_result
);
    import vlid_pkg::*;

    t_dec_state             cap;
    logic [3:0]             blk_n;
    logic [POS_W-1:0]       next_pos;
    logic                   done;

    always_comb begin
        cap   = i_state;
        blk_n = (i_code_byte[3:0] == 4'd0) ? 4'd1 : i_code_byte[3:0];
        if (i_state.pos == POS_TAG) begin
            cap.dest = '0;
            cap.src1 = '0;
            cap.src2 = '0;
            cap.imm  = '0;
            cap.cls  = i_code_byte[7:6];
            case (i_code_byte[7:6])
                CLS_SHORT: begin
                    cap.exp_len = LEN_SHORT;
                    cap.opcode  = {4'd0, i_code_byte[3:0]};
                end
                CLS_IMM16: begin
                    cap.exp_len = LEN_IMM16;
                    cap.opcode  = {3'd0, i_code_byte[4:0]};
                end
                CLS_FULL: begin
                    cap.exp_len = LEN_FULL;
                    cap.opcode  = '0;
                end
                default: begin
                    cap.exp_len = LEN_BLOCK_BASE + {blk_n, 3'b000};
                    cap.opcode  = '0;
                end
            endcase
        end else if (i_state.cls == CLS_SHORT || i_state.cls == CLS_IMM16) begin
            if (i_state.pos == POS_OP) begin
                cap.dest = {4'd0, i_code_byte[7:4]};
                cap.src1 = {4'd0, i_code_byte[3:0]};
            end else if (i_state.cls == CLS_IMM16 && i_state.pos == POS_DEST) begin
                cap.imm = {24'd0, i_code_byte};
            end else if (i_state.cls == CLS_IMM16 && i_state.pos == POS_SRC1) begin
                cap.imm = {{16{i_code_byte[7]}}, i_code_byte, i_state.imm[7:0]};
            end
        end else begin
            case (i_state.pos)
                POS_OP:     cap.opcode = i_code_byte;
                POS_DEST:   cap.dest   = i_code_byte;
                POS_SRC1:   cap.src1   = i_code_byte;
                POS_SRC2:   cap.src2   = i_code_byte;
                POS_IMM_B0: cap.imm    = {24'd0, i_code_byte};
                POS_IMM_B1: cap.imm    = i_state.imm | {16'd0, i_code_byte, 8'd0};
                POS_IMM_B2: cap.imm    = i_state.imm | {8'd0, i_code_byte, 16'd0};
                POS_IMM_B3: cap.imm    = i_state.imm | {i_code_byte, 24'd0};
                default:    cap.imm    = i_state.imm;
            endcase
        end

        next_pos = i_state.pos + 7'd1;
        cap.pos  = next_pos;
        done     = (next_pos == cap.exp_len);

        o_result = DEC_RESULT_ZERO;
        o_emit   = done || i_last;
        if (done) begin
            o_result.status = STATUS_OK;
            o_result.opcode = cap.opcode;
            o_result.dest   = cap.dest;
            o_result.src1   = cap.src1;
            o_result.src2   = cap.src2;
            o_result.imm    = cap.imm;
            o_result.len    = cap.exp_len;
        end else if (i_last) begin
            o_result.status = STATUS_TRUNC;
        end
        o_state = o_emit ? DEC_STATE_CLEAR : cap;
    end

endmodule

`default_nettype wire

@@ rtl/core/var_length_instruction_decoder_core.sv @@
// ----------------------------------------------------------------------------
// var_length_instruction_decoder_core
// Decodes variable-length virtual-machine instructions from a byte stream.
// ----------------------------------------------------------------------------
// One code byte is taken per cycle on the slave side; tlast marks the last
// byte of the stream. Each byte passes an input register, then one step of
// decode logic that updates the held fields and the byte counter, and a
// finished instruction lands in the output register. The result of the
// final byte of an instruction is offered on the master side from the output
// register, once that byte has passed the input register and the decode step.
// Sustained rate is one byte per cycle while the master side takes results;
// a stall there holds the output register and then the input register.
// tuser bit 0 is the status: 0 decoded, 1 stream ended mid-instruction
// (all tdata fields then zero). The decoder then waits for a new tag byte.
`default_nettype none

module var_length_instruction_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
    input  logic        s_axis_tlast,   // stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] opcode, [15:8] dest_reg,
                                        // [23:16] src1_reg, [31:24] src2_reg,
                                        // [63:32] immediate, [70:64] instr_length
    output logic        m_axis_tuser    // [0] status
);
    import vlid_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_dec_state  r_state;
    t_dec_state  n_state;
    logic        r_out_valid;
    t_dec_result r_out;
    t_dec_result n_out;
    logic        step_emit;
    logic        advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    vlid_step u_step (
        .i_state     (r_state),
        .i_code_byte (r_in_byte),
        .i_last      (r_in_last),
        .o_state     (n_state),
        .o_emit      (step_emit),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= DEC_STATE_CLEAR;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= step_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && step_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {1'b0, r_out.len, r_out.imm, r_out.src2,
                            r_out.src1, r_out.dest, r_out.opcode};

endmodule

`default_nettype wire

@@ rtl/core/vlid_checker.sv @@
// ----------------------------------------------------------------------------
// vlid_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vlid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import vlid_pkg::*;

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_TRUNC) |-> (m_axis_tdata == 72'd0))
        else $error("truncated result carries nonzero fields");

    a_length_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_OK) |->
            (m_axis_tdata[70:64] == LEN_IMM16 || m_axis_tdata[70:64] == LEN_FULL ||
             (m_axis_tdata[66:64] == 3'd2 && m_axis_tdata[70:64] <= 7'd122)))
        else $error("decoded instruction has impossible length");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind var_length_instruction_decoder_core vlid_checker u_vlid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ test/var_length_instruction_decoder_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// var_length_instruction_decoder_core_tb
// Self-checking bench for the variable-length instruction decoder.
// ----------------------------------------------------------------------------
// A short table of code bytes exercises every class, the field extremes, a
// stream end on a tag byte, in mid-instruction and on the final byte. Random
// instruction streams follow, mostly well formed with random content, plus
// truncated instructions and loose noise bytes. Each accepted byte runs
// through a bit-accurate decoder model in the bench, and every result on the
// master side is compared field by field with the oldest decoded instruction
// still waiting. Both sides pause in random bursts, and once the master side
// holds off long enough for the decoder to back up into its input.
// ----------------------------------------------------------------------------

module var_length_instruction_decoder_core_tb;

    import vlid_pkg::*;

    localparam int RAND_BYTES  = 950;
    localparam int CALM_TAIL   = 120;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN       = 8;
    localparam int LIMIT       = 200000;
    localparam int DIR_ROWS    = 28;

    localparam t_dec_result TRUNC_RES = '{status: STATUS_TRUNC, default: '0};
    localparam t_dec_result NO_RES    = DEC_RESULT_ZERO;

    typedef struct packed {
        logic [7:0]  code;
        logic        last;
        logic        known;
        t_dec_result want;
    } t_code_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] code_byte
    logic        s_axis_tlast;     // stream_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;     // [7:0] opcode, [15:8] dest_reg, [23:16] src1_reg,
                                   // [31:24] src2_reg, [63:32] immediate,
                                   // [70:64] instr_length
    logic        m_axis_tuser;     // [0] status

    t_dec_state  dec_st;
    t_dec_result pending_instrs [$];
    t_code_row   code_stream [$];
    int          err_cnt    = 0;
    int          bytes_sent = 0;
    int          cycle_cnt  = 0;
    bit          no_idle    = 1'b0;

    t_code_row directed_rows [0:DIR_ROWS-1] = '{
        '{8'hC5, 1'b1, 1'b1, TRUNC_RES},
        '{8'h3F, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b1, '{STATUS_OK, 8'h0F, 8'h0F, 8'h0F, 8'h00, 32'h0, LEN_SHORT}},
        '{8'h7F, 1'b0, 1'b0, NO_RES},
        '{8'hA5, 1'b0, 1'b0, NO_RES},
        '{8'h34, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b0, 1'b1,
          '{STATUS_OK, 8'h1F, 8'h0A, 8'h05, 8'h00, 32'hFFFF8034, LEN_IMM16}},
        '{8'h40, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b1, TRUNC_RES},
        '{8'hBF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h12, 1'b0, 1'b0, NO_RES},
        '{8'h34, 1'b0, 1'b0, NO_RES},
        '{8'h56, 1'b0, 1'b0, NO_RES},
        '{8'h78, 1'b0, 1'b0, NO_RES},
        '{8'h9A, 1'b0, 1'b0, NO_RES},
        '{8'hBC, 1'b0, 1'b0, NO_RES},
        '{8'hDE, 1'b0, 1'b1,
          '{STATUS_OK, 8'hFF, 8'h12, 8'h34, 8'h56, 32'hDEBC9A78, LEN_FULL}},
        '{8'hC0, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h02, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, NO_RES},
        '{8'h04, 1'b0, 1'b0, NO_RES},
        '{8'h05, 1'b0, 1'b0, NO_RES},
        '{8'h06, 1'b0, 1'b0, NO_RES},
        '{8'h07, 1'b0, 1'b0, NO_RES},
        '{8'h08, 1'b0, 1'b0, NO_RES},
        '{8'h99, 1'b0, 1'b0, NO_RES}
    };

    var_length_instruction_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit decode_byte(input logic [7:0] b, input logic stream_end,
                                       output t_dec_result res);
        logic [3:0] blocks;
        bit         done;
        done = 1'b0;
        res  = DEC_RESULT_ZERO;
        if (dec_st.pos == POS_TAG) begin
            dec_st.dest = '0;
            dec_st.src1 = '0;
            dec_st.src2 = '0;
            dec_st.imm  = '0;
            dec_st.cls  = b[7:6];
            case (dec_st.cls)
                CLS_SHORT: begin
                    dec_st.exp_len = LEN_SHORT;
                    dec_st.opcode  = {4'h0, b[3:0]};
                end
                CLS_IMM16: begin
                    dec_st.exp_len = LEN_IMM16;
                    dec_st.opcode  = {3'h0, b[4:0]};
                end
                CLS_FULL: begin
                    dec_st.exp_len = LEN_FULL;
                    dec_st.opcode  = '0;
                end
                default: begin
                    blocks = (b[3:0] == 4'h0) ? 4'h1 : b[3:0];
                    dec_st.exp_len = LEN_BLOCK_BASE + {blocks, 3'b000};
                    dec_st.opcode  = '0;
                end
            endcase
        end else if (dec_st.cls == CLS_SHORT || dec_st.cls == CLS_IMM16) begin
            if (dec_st.pos == POS_OP) begin
                dec_st.dest = {4'h0, b[7:4]};
                dec_st.src1 = {4'h0, b[3:0]};
            end else if (dec_st.cls == CLS_IMM16 && dec_st.pos == POS_DEST) begin
                dec_st.imm = {24'h0, b};
            end else if (dec_st.cls == CLS_IMM16 && dec_st.pos == POS_SRC1) begin
                dec_st.imm = {{16{b[7]}}, b, dec_st.imm[7:0]};
            end
        end else begin
            case (dec_st.pos)
                POS_OP:     dec_st.opcode     = b;
                POS_DEST:   dec_st.dest       = b;
                POS_SRC1:   dec_st.src1       = b;
                POS_SRC2:   dec_st.src2       = b;
                POS_IMM_B0: dec_st.imm        = {24'h0, b};
                POS_IMM_B1: dec_st.imm[15:8]  = b;
                POS_IMM_B2: dec_st.imm[23:16] = b;
                POS_IMM_B3: dec_st.imm[31:24] = b;
                default: ;
            endcase
        end
        dec_st.pos = dec_st.pos + 1'b1;
        if (dec_st.pos == dec_st.exp_len) begin
            res  = '{STATUS_OK, dec_st.opcode, dec_st.dest, dec_st.src1, dec_st.src2,
                     dec_st.imm, dec_st.exp_len};
            done = 1'b1;
            dec_st = DEC_STATE_CLEAR;
        end else if (stream_end) begin
            res  = TRUNC_RES;
            done = 1'b1;
            dec_st = DEC_STATE_CLEAR;
        end
        return done;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_dec_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_instrs.size() == 0) begin
                $error("result transfer with no instruction pending");
                err_cnt++;
            end else begin
                want = pending_instrs.pop_front();
                check_field("status",       32'(want.status), 32'(m_axis_tuser));
                check_field("opcode",       32'(want.opcode), 32'(m_axis_tdata[7:0]));
                check_field("dest_reg",     32'(want.dest),   32'(m_axis_tdata[15:8]));
                check_field("src1_reg",     32'(want.src1),   32'(m_axis_tdata[23:16]));
                check_field("src2_reg",     32'(want.src2),   32'(m_axis_tdata[31:24]));
                check_field("immediate",    want.imm,         m_axis_tdata[63:32]);
                check_field("instr_length", 32'(want.len),    32'(m_axis_tdata[70:64]));
            end
        end
    end

    // result side: random stalls, one long hold-off once traffic is flowing
    initial begin
        bit held_off;
        held_off = 1'b0;
        m_axis_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && bytes_sent >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (no_idle || ((cycle_cnt / 200) % 3 == 2) ||
                         $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_dec_result res;
        t_code_row   row;
        logic [7:0]  tag;
        logic [3:0]  blocks;
        int          len;
        int          cut;
        int          pick;
        bit          got;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        dec_st = DEC_STATE_CLEAR;

        foreach (directed_rows[i]) code_stream.push_back(directed_rows[i]);
        while (code_stream.size() < DIR_ROWS + RAND_BYTES) begin
            row = '0;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 5)) begin
                    row.code = 8'($urandom);
                    row.last = ($urandom_range(0, 3) == 0);
                    code_stream.push_back(row);
                end
            end else begin
                pick = $urandom_range(0, 9);
                tag  = 8'($urandom);
                tag[7:6] = (pick < 3) ? CLS_SHORT : (pick < 6) ? CLS_IMM16 :
                           (pick < 9) ? CLS_FULL : CLS_BLOCK;
                case (tag[7:6])
                    CLS_SHORT: len = LEN_SHORT;
                    CLS_IMM16: len = LEN_IMM16;
                    CLS_FULL:  len = LEN_FULL;
                    default: begin
                        tag[3:0] = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15))
                                                                : 4'($urandom_range(0, 2));
                        blocks = (tag[3:0] == 4'h0) ? 4'h1 : tag[3:0];
                        len = LEN_BLOCK_BASE + 8 * blocks;
                    end
                endcase
                cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : len;
                for (int k = 0; k < cut; k++) begin
                    row.code = (k == 0) ? tag : 8'($urandom);
                    row.last = 1'b0;
                    if (k == cut - 1)
                        row.last = (cut < len) || ($urandom_range(0, 5) == 0);
                    code_stream.push_back(row);
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (code_stream[i]) begin
            no_idle = (i >= code_stream.size() - CALM_TAIL);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= code_stream[i].code;
            s_axis_tlast  <= code_stream[i].last;
            do @(posedge i_clk); while (!s_axis_tready);
            got = decode_byte(code_stream[i].code, code_stream[i].last, res);
            if (code_stream[i].known)
                pending_instrs.push_back(code_stream[i].want);
            else if (got)
                pending_instrs.push_back(res);
            bytes_sent++;
            if (!no_idle && ((i / 80) % 3 != 2) && $urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (pending_instrs.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
